// ----- rtl/button_stepped_servo_pulse_unit_macros.svh -----
// ----------------------------------------------------------------------------
// button stepped servo pulse unit assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BUTTON_STEPPED_SERVO_PULSE_UNIT_MACROS_SVH
`define BUTTON_STEPPED_SERVO_PULSE_UNIT_MACROS_SVH

// same cycle implication
`define BSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication
`define BSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp_pkg
// types, constants and helpers of the button stepped servo pulse unit
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int unsigned STEP_DIV_DFLT  = 18;
  localparam int unsigned COUNT_W_DFLT   = 16;

  localparam int unsigned STEP_SHIFT     = 16;

  localparam logic [7:0]  ADJ_MIN_RST    = 8'd56;
  localparam logic [7:0]  ADJ_MAX_RST    = 8'd111;
  localparam logic [15:0] PWM_LOAD_RST   = 16'd11362;

  localparam int unsigned PW_SHIFT       = 34;
  localparam logic [63:0] PW_DIV         = 64'd1000;
  localparam logic [63:0] PW_RECIP_W     = ((64'd1 << PW_SHIFT) + PW_DIV - 64'd1) / PW_DIV;
  localparam logic [24:0] PW_RECIP       = PW_RECIP_W[24:0];

  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0]  LED_A          = 4'd2;
  localparam logic [3:0]  LED_B          = 4'd4;
  localparam logic [3:0]  LED_C          = 4'd8;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_HELD    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CFG_ADJ_MIN  = 2'd0,
    CFG_ADJ_MAX  = 2'd1,
    CFG_PWM_LOAD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic dn_conf;
    logic up_conf;
    logic dn_held;
    logic up_held;
  } bsp_cls_t;

  function automatic logic [3:0] led_rotate(input logic [3:0] led);
    logic [3:0] nxt;
    if (led == LED_A) begin
      nxt = LED_B;
    end else if (led == LED_B) begin
      nxt = LED_C;
    end else begin
      nxt = LED_A;
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/bsp_front.sv -----
// ----------------------------------------------------------------------------
// bsp_front
// accepts button samples, debounces both buttons and classifies each request
// ----------------------------------------------------------------------------
module bsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_tdata_i,
  input  logic              q_full_i,
  output logic              push_o,
  output bsp_pkg::bsp_cls_t cls_o
);
  import bsp_pkg::*;

  phase_e dn_phase_q, dn_phase_d;
  phase_e up_phase_q, up_phase_d;
  logic   dn_low, up_low;
  logic   accept;

  assign dn_low     = ~s_tdata_i[0];
  assign up_low     = ~s_tdata_i[1];
  assign s_tready_o = ~q_full_i;
  assign accept     = s_tvalid_i & s_tready_o;
  assign push_o     = accept;

  // next state
  always_comb begin
    dn_phase_d = dn_phase_q;
    up_phase_d = up_phase_q;
    if (accept) begin
      unique case (dn_phase_q)
        PH_PRESSED: dn_phase_d = dn_low ? PH_HELD : PH_IDLE;
        PH_HELD:    dn_phase_d = dn_low ? PH_HELD : PH_IDLE;
        default:    dn_phase_d = dn_low ? PH_PRESSED : PH_IDLE;
      endcase
      unique case (up_phase_q)
        PH_PRESSED: up_phase_d = up_low ? PH_HELD : PH_IDLE;
        PH_HELD:    up_phase_d = up_low ? PH_HELD : PH_IDLE;
        default:    up_phase_d = up_low ? PH_PRESSED : PH_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    cls_o.dn_conf = (dn_phase_q == PH_PRESSED) & dn_low;
    cls_o.up_conf = (up_phase_q == PH_PRESSED) & up_low;
    cls_o.dn_held = (dn_phase_d == PH_HELD);
    cls_o.up_held = (up_phase_d == PH_HELD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_phase_q <= PH_IDLE;
      up_phase_q <= PH_IDLE;
    end else begin
      dn_phase_q <= dn_phase_d;
      up_phase_q <= up_phase_d;
    end
  end

endmodule

// ----- rtl/bsp_queue.sv -----
// ----------------------------------------------------------------------------
// bsp_queue
// short request queue between the front and back parts
// ----------------------------------------------------------------------------
`include "button_stepped_servo_pulse_unit_macros.svh"

module bsp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bsp_pkg::bsp_cls_t din_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bsp_pkg::bsp_cls_t dout_o
);
  import bsp_pkg::*;

  bsp_cls_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  `BSP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
  `BSP_ASSERT_NEXT(a_cnt_grow, push_i && !pop_i, cnt_q == $past(cnt_q) + QCNT_W'(1), "count not up")
  `BSP_ASSERT_NEXT(a_cnt_drop, pop_i && !push_i, cnt_q == $past(cnt_q) - QCNT_W'(1), "count not down")

endmodule

// ----- rtl/bsp_back.sv -----
// ----------------------------------------------------------------------------
// bsp_back
// applies confirmed presses to the adjust state and scales the pulse width
// ----------------------------------------------------------------------------
`include "button_stepped_servo_pulse_unit_macros.svh"

module bsp_back #(
  parameter int unsigned STEP_DIVISOR = bsp_pkg::STEP_DIV_DFLT,
  parameter int unsigned COUNT_WIDTH  = bsp_pkg::COUNT_W_DFLT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  bsp_pkg::bsp_cls_t cls_i,
  output logic              pop_o,
  input  logic [7:0]        adj_min_i,
  input  logic [7:0]        adj_max_i,
  input  logic [15:0]       pwm_load_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [63:0]       m_tdata_o
);
  import bsp_pkg::*;

  localparam logic [16:0] STEP_RECIP =
    17'(((1 << STEP_SHIFT) + STEP_DIVISOR - 1) / STEP_DIVISOR);

  logic [7:0]             diff;
  logic [24:0]            step_prod;
  logic [7:0]             step_q;

  logic [7:0]             lvl_q, lvl_dn, lvl_new;
  logic [8:0]             sum9;
  logic [3:0]             led_q, led_dn, led_new;
  logic [COUNT_WIDTH-1:0] dn_cnt_q, up_cnt_q;
  logic                   dn_held_q, up_held_q;
  logic [23:0]            prod_q, prod_d;

  logic                   av_q, ov_q;
  logic                   adv_a, adv_b, pop;

  logic [48:0]            pw_prod;
  logic [14:0]            pw_q;
  logic [3:0]             o_led_q;
  logic                   o_dn_held_q, o_up_held_q;
  logic [15:0]            o_dn_cnt_q, o_up_cnt_q;
  logic [7:0]             o_lvl_q;
  logic [31:0]            dn_cnt_ext, up_cnt_ext;

  // step from the limit registers
  always_comb begin
    diff      = (adj_max_i >= adj_min_i) ? (adj_max_i - adj_min_i) : 8'd0;
    step_prod = 25'(diff) * 25'(STEP_RECIP);
  end

  assign adv_b = ~ov_q | m_tready_i;
  assign adv_a = ~av_q | adv_b;
  assign pop   = q_valid_i & adv_a;
  assign pop_o = pop;

  // press update, down first then up
  always_comb begin
    lvl_dn = lvl_q;
    led_dn = led_q;
    if (cls_i.dn_conf) begin
      led_dn = led_rotate(led_q);
      if ((lvl_q < step_q) || ((lvl_q - step_q) < adj_min_i)) begin
        lvl_dn = adj_min_i;
      end else begin
        lvl_dn = lvl_q - step_q;
      end
    end
    sum9    = {1'b0, lvl_dn} + {1'b0, step_q};
    lvl_new = lvl_dn;
    led_new = led_dn;
    if (cls_i.up_conf) begin
      led_new = led_rotate(led_dn);
      lvl_new = (sum9 > {1'b0, adj_max_i}) ? adj_max_i : sum9[7:0];
    end
    prod_d = 24'(lvl_new) * 24'(pwm_load_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      lvl_q     <= ADJ_MIN_RST;
      led_q     <= LED_A;
      dn_cnt_q  <= '0;
      up_cnt_q  <= '0;
      dn_held_q <= 1'b0;
      up_held_q <= 1'b0;
      av_q      <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      step_q <= step_prod[STEP_SHIFT+7:STEP_SHIFT];
      av_q   <= pop | (av_q & ~adv_b);
      if (adv_b) begin
        ov_q <= av_q;
      end
      if (pop) begin
        lvl_q     <= lvl_new;
        led_q     <= led_new;
        dn_held_q <= cls_i.dn_held;
        up_held_q <= cls_i.up_held;
        if (cls_i.dn_conf) begin
          dn_cnt_q <= dn_cnt_q + COUNT_WIDTH'(1);
        end
        if (cls_i.up_conf) begin
          up_cnt_q <= up_cnt_q + COUNT_WIDTH'(1);
        end
      end
    end
  end

  // divide by 1000 through a reciprocal
  assign pw_prod    = 49'(prod_q) * 49'(PW_RECIP);
  assign dn_cnt_ext = 32'(dn_cnt_q);
  assign up_cnt_ext = 32'(up_cnt_q);

  always_ff @(posedge clk_i) begin
    if (pop) begin
      prod_q <= prod_d;
    end
    if (av_q && adv_b) begin
      pw_q        <= pw_prod[PW_SHIFT+14:PW_SHIFT];
      o_led_q     <= led_q;
      o_dn_held_q <= dn_held_q;
      o_up_held_q <= up_held_q;
      o_dn_cnt_q  <= dn_cnt_ext[15:0];
      o_up_cnt_q  <= up_cnt_ext[15:0];
      o_lvl_q     <= lvl_q;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {3'b000, o_lvl_q, o_up_cnt_q, o_dn_cnt_q,
                       o_up_held_q, o_dn_held_q, o_led_q, pw_q};

  `BSP_ASSERT_NOW(a_led_onehot, 1'b1, $onehot(led_q) && !led_q[0], "led pattern broken")
  `BSP_ASSERT_NEXT(a_cnt_hold, !pop, $stable(dn_cnt_q) && $stable(up_cnt_q), "count moved")
  `BSP_ASSERT_NEXT(a_out_load, av_q && adv_b, ov_q, "result lost")

endmodule

// ----- rtl/button_stepped_servo_pulse_unit.sv -----
// ----------------------------------------------------------------------------
// button_stepped_servo_pulse_unit
// debounced two-button servo adjust with scaled pulse width output
//
//   channel   direction   payload
//   s_axis    in          button sample (tdata: down level, up level)
//   m_axis    out         pulse width, led, held flags, counts, adjust
//   cfg       in          register write (adjust min, adjust max, pwm load)
//
// one sample accepted per cycle while the queue is not full, one result per sample
// each result is registered through the queue, the update stage and the output stage
// a four-entry queue lets the front accept while the output is stalled
// all control state clears on rst_ni, no clearing pass
// ----------------------------------------------------------------------------
module button_stepped_servo_pulse_unit #(
  parameter int unsigned STEP_DIVISOR = bsp_pkg::STEP_DIV_DFLT,
  parameter int unsigned COUNT_WIDTH  = bsp_pkg::COUNT_W_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] down_button_level, [1] up_button_level
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] pulse_width, [18:15] led_pattern, [19] down_held, [20] up_held,
  // [36:21] down_presses, [52:37] up_presses, [60:53] adjust_now
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import bsp_pkg::*;

  logic [7:0]  adj_min_q, adj_max_q;
  logic [15:0] pwm_load_q;

  logic        q_full, q_push, q_pop, q_valid;
  bsp_cls_t    cls_in, cls_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_min_q  <= ADJ_MIN_RST;
      adj_max_q  <= ADJ_MAX_RST;
      pwm_load_q <= PWM_LOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_ADJ_MIN:  adj_min_q  <= cfg_wdata_i[7:0];
        CFG_ADJ_MAX:  adj_max_q  <= cfg_wdata_i[7:0];
        CFG_PWM_LOAD: pwm_load_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cls_o      (cls_in)
  );

  bsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (cls_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .dout_o  (cls_out)
  );

  bsp_back #(
    .STEP_DIVISOR (STEP_DIVISOR),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .cls_i      (cls_out),
    .pop_o      (q_pop),
    .adj_min_i  (adj_min_q),
    .adj_max_i  (adj_max_q),
    .pwm_load_i (pwm_load_q),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// ----- tb/button_stepped_servo_pulse_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_stepped_servo_pulse_unit_tb
// feeds raw two-button samples under several register settings, with
// random gaps on both stream sides, and checks each report field by field
// against a local model of the debouncers, the adjust clamp and the counters
// ----------------------------------------------------------------------------
module button_stepped_servo_pulse_unit_tb;
  import bsp_pkg::*;

  localparam int unsigned STEP_DIV       = STEP_DIV_DFLT;
  localparam int unsigned PULSE_SCALE    = 1000;
  localparam logic [1:0]  CFG_SPARE      = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned MAX_SHOWN      = 10;
  localparam int unsigned IDLE_MAX       = 8;
  localparam int unsigned RAND_PHASES    = 8;
  localparam int unsigned RAND_PER_PHASE = 106;
  localparam int unsigned IDLE_STRETCH   = 35;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned DIRECTED_ROWS  = 18;

  typedef struct packed {
    logic [7:0]  adjust;
    logic [15:0] up_cnt;
    logic [15:0] dn_cnt;
    logic        up_held;
    logic        dn_held;
    logic [3:0]  led;
    logic [14:0] pulse;
  } servo_report_t;

  typedef struct packed {
    logic          dn_lvl;
    logic          up_lvl;
    logic          typed;
    servo_report_t want;
  } sample_row_t;

  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] load;
  } servo_setting_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [0] down_button_level, [1] up_button_level
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [14:0] pulse_width, [18:15] led_pattern, [19] down_held, [20] up_held,
  // [36:21] down_presses, [52:37] up_presses, [60:53] adjust_now
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;

  // model state
  logic [7:0]    reg_min;
  logic [7:0]    reg_max;
  logic [15:0]   reg_load;
  phase_e        dn_phase;
  phase_e        up_phase;
  logic          dn_flag;
  logic          up_flag;
  logic [7:0]    adjust_level;
  logic [3:0]    led_now;
  logic [15:0]   dn_total;
  logic [15:0]   up_total;
  servo_report_t reports_due[$];

  logic        tx_idle_on;
  logic        rx_idle_on;
  int unsigned mismatch_cnt = 0;
  int unsigned samples_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned cycle_cnt    = 0;

  button_stepped_servo_pulse_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("run stopped at cycle limit, %0d reports still pending", reports_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [3:0] led_next(input logic [3:0] v);
    case (v)
      LED_A:   return LED_B;
      LED_B:   return LED_C;
      default: return LED_A;
    endcase
  endfunction

  function automatic int unsigned pick_hold_len();
    // mostly confirmed presses, now and then a single-sample bounce
    if ($urandom_range(0, 9) == 0) return 1;
    return $urandom_range(2, 6);
  endfunction

  task automatic debounce_step(input logic low, inout phase_e ph, inout logic held,
                               output logic hit);
    hit = 1'b0;
    case (ph)
      PH_PRESSED: begin
        if (low) begin
          ph   = PH_HELD;
          held = 1'b1;
          hit  = 1'b1;
        end else begin
          ph = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!low) begin
          ph   = PH_IDLE;
          held = 1'b0;
        end
      end
      default: ph = low ? PH_PRESSED : PH_IDLE;
    endcase
  endtask

  task automatic predict_servo_sample(input logic dn_lvl, input logic up_lvl,
                                      output servo_report_t r);
    int unsigned step;
    int unsigned lvl;
    int unsigned pw;
    logic        hit;
    step = 0;
    if (reg_max >= reg_min) step = (int'(reg_max) - int'(reg_min)) / STEP_DIV;
    lvl = 32'(adjust_level);
    // down is handled before up within one sample
    debounce_step(!dn_lvl, dn_phase, dn_flag, hit);
    if (hit) begin
      dn_total = dn_total + 16'd1;
      led_now  = led_next(led_now);
      if (lvl < step || lvl - step < reg_min) lvl = 32'(reg_min);
      else lvl = lvl - step;
    end
    debounce_step(!up_lvl, up_phase, up_flag, hit);
    if (hit) begin
      up_total = up_total + 16'd1;
      led_now  = led_next(led_now);
      if (lvl + step > reg_max) lvl = 32'(reg_max);
      else lvl = lvl + step;
    end
    adjust_level = lvl[7:0];
    pw = (lvl * int'(reg_load)) / PULSE_SCALE;
    r.pulse   = pw[14:0];
    r.led     = led_now;
    r.dn_held = dn_flag;
    r.up_held = up_flag;
    r.dn_cnt  = dn_total;
    r.up_cnt  = up_total;
    r.adjust  = adjust_level;
  endtask

  task automatic send_sample(input logic dn_lvl, input logic up_lvl, input logic typed,
                             input servo_report_t want);
    int unsigned   gap;
    servo_report_t r;
    gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, up_lvl, dn_lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_servo_sample(dn_lvl, up_lvl, r);
    reports_due.push_back(typed ? want : r);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ADJ_MIN:  reg_min  = val[7:0];
      CFG_ADJ_MAX:  reg_max  = val[7:0];
      CFG_PWM_LOAD: reg_load = val;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic check_report(input servo_report_t got);
    servo_report_t want;
    reports_seen++;
    if (reports_due.size() == 0) begin
      flag_mismatch("report with no request pending, adjust", 0, got.adjust);
      return;
    end
    want = reports_due.pop_front();
    if (got.pulse   !== want.pulse)   flag_mismatch("pulse width", want.pulse, got.pulse);
    if (got.led     !== want.led)     flag_mismatch("led pattern", want.led, got.led);
    if (got.dn_held !== want.dn_held) flag_mismatch("down held", want.dn_held, got.dn_held);
    if (got.up_held !== want.up_held) flag_mismatch("up held", want.up_held, got.up_held);
    if (got.dn_cnt  !== want.dn_cnt)  flag_mismatch("down presses", want.dn_cnt, got.dn_cnt);
    if (got.up_cnt  !== want.up_cnt)  flag_mismatch("up presses", want.up_cnt, got.up_cnt);
    if (got.adjust  !== want.adjust)  flag_mismatch("adjust now", want.adjust, got.adjust);
  endtask

  initial begin : report_sink
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      check_report(m_axis_tdata[60:0]);
    end
  end

  initial begin : stimulus
    sample_row_t    directed_rows [DIRECTED_ROWS];
    servo_setting_t settings [RAND_PHASES];
    int unsigned    dn_left;
    int unsigned    up_left;
    logic           dn_lvl;
    logic           up_lvl;
    logic [7:0]     junk;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_ADJ_MIN;
    cfg_wdata_i   <= '0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;

    reg_min      = ADJ_MIN_RST;
    reg_max      = ADJ_MAX_RST;
    reg_load     = PWM_LOAD_RST;
    dn_phase     = PH_IDLE;
    up_phase     = PH_IDLE;
    dn_flag      = 1'b0;
    up_flag      = 1'b0;
    adjust_level = ADJ_MIN_RST;
    led_now      = LED_A;
    dn_total     = '0;
    up_total     = '0;

    // down, up, typed, then the typed report
    directed_rows[0]  = {1'b1, 1'b1, 1'b1, 8'd56, 16'd0, 16'd0, 1'b0, 1'b0, LED_A, 15'd636};
    directed_rows[1]  = {1'b0, 1'b1, 1'b0, 61'd0};
    // first down press clamps at the minimum
    directed_rows[2]  = {1'b0, 1'b1, 1'b1, 8'd56, 16'd0, 16'd1, 1'b0, 1'b1, LED_B, 15'd636};
    directed_rows[3]  = {1'b0, 1'b1, 1'b0, 61'd0};
    directed_rows[4]  = {1'b1, 1'b1, 1'b0, 61'd0};
    directed_rows[5]  = {1'b1, 1'b0, 1'b0, 61'd0};
    directed_rows[6]  = {1'b1, 1'b0, 1'b0, 61'd0};
    directed_rows[7]  = {1'b1, 1'b1, 1'b0, 61'd0};
    // single low sample bounces back to idle
    directed_rows[8]  = {1'b0, 1'b1, 1'b0, 61'd0};
    directed_rows[9]  = {1'b1, 1'b1, 1'b0, 61'd0};
    // both confirm together, led steps twice
    directed_rows[10] = {1'b0, 1'b0, 1'b0, 61'd0};
    directed_rows[11] = {1'b0, 1'b0, 1'b0, 61'd0};
    directed_rows[12] = {1'b0, 1'b0, 1'b0, 61'd0};
    directed_rows[13] = {1'b1, 1'b0, 1'b0, 61'd0};
    directed_rows[14] = {1'b0, 1'b1, 1'b0, 61'd0};
    directed_rows[15] = {1'b0, 1'b1, 1'b0, 61'd0};
    directed_rows[16] = {1'b1, 1'b1, 1'b0, 61'd0};
    directed_rows[17] = {1'b1, 1'b1, 1'b0, 61'd0};

    settings[0] = {8'd0, 8'd255, 16'd65535};
    settings[1] = {8'd200, 8'd100, 16'd1};
    settings[2] = {8'd255, 8'd255, 16'd1000};
    settings[3] = {8'd0, 8'd0, 16'd1};
    settings[4] = {ADJ_MIN_RST, ADJ_MAX_RST, PWM_LOAD_RST};
    for (int i = 5; i < RAND_PHASES; i++) begin
      settings[i].lo   = 8'($urandom_range(0, 255));
      settings[i].hi   = 8'($urandom_range(0, 255));
      settings[i].load = 16'($urandom_range(1, 65535));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (directed_rows[i])
      send_sample(directed_rows[i].dn_lvl, directed_rows[i].up_lvl, directed_rows[i].typed,
                  directed_rows[i].want);

    dn_left = 0;
    up_left = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clk_i);
      junk = 8'($urandom);
      write_reg(CFG_SPARE, 16'($urandom));
      write_reg(CFG_ADJ_MIN, {junk, settings[ph].lo});
      junk = 8'($urandom);
      write_reg(CFG_ADJ_MAX, {junk, settings[ph].hi});
      write_reg(CFG_PWM_LOAD, settings[ph].load);

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % IDLE_STRETCH == 0) begin
          tx_idle_on = ($urandom_range(0, 2) != 0);
          rx_idle_on = ($urandom_range(0, 2) != 0);
        end
        if (dn_left == 0 && $urandom_range(0, 3) == 0) dn_left = pick_hold_len();
        if (up_left == 0 && $urandom_range(0, 3) == 0) up_left = pick_hold_len();
        dn_lvl = (dn_left == 0);
        up_lvl = (up_left == 0);
        if (dn_left != 0) dn_left--;
        if (up_left != 0) up_left--;
        // occasional noise sample
        if ($urandom_range(0, 15) == 0) dn_lvl = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 15) == 0) up_lvl = 1'($urandom_range(0, 1));
        send_sample(dn_lvl, up_lvl, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d reports for %0d button samples, %0d mismatches",
             reports_seen, samples_sent, mismatch_cnt);
    $display("%0d register settings incl. extremes and min above max, random stream gaps",
             RAND_PHASES);
    if (mismatch_cnt == 0 && reports_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
